// ===== rtl/cfa_pkg.sv =====
// ============================================================================
// cfa_pkg : shared types, constants and microprogram
// Field widths, sequencer step codes, control word layout and the control
// store for the continued fraction approximation block.
// ============================================================================
`default_nettype none

package cfa_pkg;

    // Field widths and defaults
    localparam int VALUE_W        = 49;
    localparam int TOL_W          = 33;
    localparam int DEN_W          = 33;
    localparam int CNT_W          = $clog2(VALUE_W);
    localparam int MAX_TERMS_DEF  = 64;
    localparam int FRAC_BITS_DEF  = 32;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(4295);

    // Sequencer step addresses
    typedef enum logic [3:0] {
        S_WAIT    = 4'd0,
        S_CHECK   = 4'd1,
        S_DIV1    = 4'd2,
        S_RUN1    = 4'd3,
        S_MAC     = 4'd4,
        S_MACRUN  = 4'd5,
        S_UPD     = 4'd6,
        S_RUN2    = 4'd7,
        S_TEST    = 4'd8,
        S_EXACT   = 4'd9,
        S_ADV     = 4'd10,
        S_FAIL    = 4'd11,
        S_PASS    = 4'd12
    } step_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_LOAD,
        OP_DIV_RUN,
        OP_MAC_LOAD,
        OP_MAC_RUN,
        OP_UPDATE,
        OP_ADVANCE,
        OP_FAIL,
        OP_PASS
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_IDLE,
        C_LIMIT,
        C_BIT_MORE,
        C_QUO_LT_TOL,
        C_REM_ZERO
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    // Divider control between sequencer and divider
    typedef struct packed {
        logic load;
        logic step;
    } div_ctl_t;

    // Control store: one word per step
    function automatic ctrl_word_t cfa_prog(input step_t pc);
        ctrl_word_t w;
        case (pc)
            S_WAIT:   w = '{op: OP_LOAD,     cond: C_IDLE,       target: S_WAIT};
            S_CHECK:  w = '{op: OP_NONE,     cond: C_LIMIT,      target: S_FAIL};
            S_DIV1:   w = '{op: OP_DIV_LOAD, cond: C_NEVER,      target: S_WAIT};
            S_RUN1:   w = '{op: OP_DIV_RUN,  cond: C_BIT_MORE,   target: S_RUN1};
            S_MAC:    w = '{op: OP_MAC_LOAD, cond: C_NEVER,      target: S_WAIT};
            S_MACRUN: w = '{op: OP_MAC_RUN,  cond: C_BIT_MORE,   target: S_MACRUN};
            S_UPD:    w = '{op: OP_UPDATE,   cond: C_NEVER,      target: S_WAIT};
            S_RUN2:   w = '{op: OP_DIV_RUN,  cond: C_BIT_MORE,   target: S_RUN2};
            S_TEST:   w = '{op: OP_NONE,     cond: C_QUO_LT_TOL, target: S_PASS};
            S_EXACT:  w = '{op: OP_NONE,     cond: C_REM_ZERO,   target: S_FAIL};
            S_ADV:    w = '{op: OP_ADVANCE,  cond: C_ALWAYS,     target: S_CHECK};
            S_FAIL:   w = '{op: OP_FAIL,     cond: C_ALWAYS,     target: S_WAIT};
            S_PASS:   w = '{op: OP_PASS,     cond: C_ALWAYS,     target: S_WAIT};
            default:  w = '{op: OP_NONE,     cond: C_ALWAYS,     target: S_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cfa_divider.sv =====
// ============================================================================
// cfa_divider : bit-serial restoring divider
// Produces one quotient bit per step, MSB first, over VALUE_W steps.
// ============================================================================
`default_nettype none

module cfa_divider
    import cfa_pkg::*;
(
    input  wire logic               clk,
    input  wire div_ctl_t           ctl,
    input  wire logic [VALUE_W-1:0] dividend,
    input  wire logic [VALUE_W-1:0] divisor,
    output logic      [VALUE_W-1:0] quotient,
    output logic      [VALUE_W-1:0] remainder
);

    logic [VALUE_W-1:0] quo_reg;
    logic [VALUE_W-1:0] quo_next;
    logic [VALUE_W-1:0] rem_reg;
    logic [VALUE_W-1:0] rem_next;
    logic [VALUE_W-1:0] dvs_reg;
    logic [VALUE_W:0]   trial;
    logic [VALUE_W:0]   diff;

    // Shift in the next dividend bit and try a subtract
    always_comb
    begin
        trial    = {rem_reg, quo_reg[VALUE_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = diff[VALUE_W] ? trial[VALUE_W-1:0] : diff[VALUE_W-1:0];
        quo_next = {quo_reg[VALUE_W-2:0], ~diff[VALUE_W]};
    end

    // Load operands or advance one bit
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (ctl.step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/continued_fraction_approximation.sv =====
// ============================================================================
// continued_fraction_approximation : best rational approximation
// Expands |value| / 2^FRAC_BITS into continued-fraction terms and returns the
// first convergent whose error is below the tolerance register.
// ============================================================================
// Pulse start while busy is low to hand in one value. The block then runs a
// microprogram over a shared bit-serial divider and a shift-add multiplier:
// each continued-fraction term takes one divide for the term, one
// multiply-accumulate for the convergent and one divide for the error test.
// A value fails when it runs out of terms or when an exact expansion still
// misses the tolerance.
// The result appears for exactly one cycle with done high and busy already
// low; the receiver cannot stall it, so it must be captured on that cycle.
// Write the tolerance only while busy is low.
`default_nettype none

module continued_fraction_approximation
    import cfa_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic        [TOL_W-1:0]   cfg_wdata,
    input  wire logic                      start,
    input  wire logic signed [VALUE_W-1:0] value,
    output logic                           busy,
    output logic                           done,
    output logic             [VALUE_W-1:0] numerator,
    output logic             [DEN_W-1:0]   denominator,
    output logic                           negative,
    output logic                           failed
);

    localparam int TERM_W = $clog2(MAX_TERMS + 1);

    step_t              pc_reg;
    step_t              pc_next;
    ctrl_word_t         cw;
    logic               jump;

    logic [TOL_W-1:0]   tol_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [TERM_W-1:0]  term_reg;
    logic               done_reg;

    logic               neg_reg;
    logic [VALUE_W-1:0] num_reg;
    logic [VALUE_W-1:0] den_reg;
    logic [VALUE_W-1:0] rem_reg;
    logic [VALUE_W-1:0] sh_reg;
    logic [VALUE_W-1:0] acc_p_reg;
    logic [VALUE_W-1:0] acc_q_reg;
    logic [VALUE_W-1:0] p1_reg;
    logic [VALUE_W-1:0] p2_reg;
    logic [VALUE_W-1:0] q1_reg;
    logic [VALUE_W-1:0] q2_reg;
    logic [VALUE_W-1:0] numerator_reg;
    logic [DEN_W-1:0]   denominator_reg;
    logic               negative_reg;
    logic               failed_reg;

    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] p_new;
    logic [VALUE_W-1:0] q_new;
    logic [VALUE_W-1:0] acc_p_next;
    logic [VALUE_W-1:0] acc_q_next;

    div_ctl_t           div_ctl;
    logic [VALUE_W-1:0] div_dividend;
    logic [VALUE_W-1:0] div_divisor;
    logic [VALUE_W-1:0] quotient;
    logic [VALUE_W-1:0] remainder;

    // Fetch the control word
    assign cw = cfa_prog(pc_reg);

    // Evaluate the jump condition
    always_comb
    begin
        case (cw.cond)
            C_NEVER:      jump = 1'b0;
            C_ALWAYS:     jump = 1'b1;
            C_IDLE:       jump = ~start;
            C_LIMIT:      jump = (term_reg == TERM_W'(MAX_TERMS));
            C_BIT_MORE:   jump = (cnt_reg != '0);
            C_QUO_LT_TOL: jump = (quotient < VALUE_W'(tol_reg));
            C_REM_ZERO:   jump = (rem_reg == '0);
            default:      jump = 1'b0;
        endcase
    end

    // Next step address
    always_comb
    begin
        if (jump)
            pc_next = cw.target;
        else
            pc_next = step_t'(4'(pc_reg + 4'd1));
    end

    // Decode divider control and operand select
    always_comb
    begin
        div_ctl.load = (cw.op == OP_DIV_LOAD) || (cw.op == OP_UPDATE);
        div_ctl.step = (cw.op == OP_DIV_RUN);
        div_dividend = (cw.op == OP_UPDATE) ? rem_reg : num_reg;
        div_divisor  = (cw.op == OP_UPDATE) ? q_new   : den_reg;
    end

    // Datapath arithmetic
    always_comb
    begin
        mag        = value[VALUE_W-1] ? VALUE_W'(-value) : VALUE_W'(value);
        p_new      = acc_p_reg + p2_reg;
        q_new      = acc_q_reg + q2_reg;
        acc_p_next = {acc_p_reg[VALUE_W-2:0], 1'b0}
                     + (sh_reg[VALUE_W-1] ? p1_reg : '0);
        acc_q_next = {acc_q_reg[VALUE_W-2:0], 1'b0}
                     + (sh_reg[VALUE_W-1] ? q1_reg : '0);
    end

    cfa_divider u_div (
        .clk       (clk),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= S_WAIT;
            tol_reg  <= TOL_RESET;
            cnt_reg  <= '0;
            term_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            done_reg <= (cw.op == OP_PASS) || (cw.op == OP_FAIL);
            if (cfg_we)
                tol_reg <= cfg_wdata;
            case (cw.op)
                OP_LOAD:
                    term_reg <= '0;
                OP_DIV_LOAD, OP_MAC_LOAD, OP_UPDATE:
                    cnt_reg <= CNT_W'(VALUE_W - 1);
                OP_DIV_RUN, OP_MAC_RUN:
                    cnt_reg <= cnt_reg - CNT_W'(1);
                OP_ADVANCE:
                    term_reg <= term_reg + TERM_W'(1);
                default:
                    cnt_reg <= cnt_reg;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cw.op)
            OP_LOAD:
            begin
                if (start)
                begin
                    neg_reg <= value[VALUE_W-1];
                    num_reg <= mag;
                    den_reg <= VALUE_W'(1) << FRAC_BITS;
                    p2_reg  <= '0;
                    q2_reg  <= VALUE_W'(1);
                    p1_reg  <= VALUE_W'(1);
                    q1_reg  <= '0;
                end
            end
            OP_MAC_LOAD:
            begin
                sh_reg    <= quotient;
                rem_reg   <= remainder;
                acc_p_reg <= '0;
                acc_q_reg <= '0;
            end
            OP_MAC_RUN:
            begin
                sh_reg    <= {sh_reg[VALUE_W-2:0], 1'b0};
                acc_p_reg <= acc_p_next;
                acc_q_reg <= acc_q_next;
            end
            OP_UPDATE:
            begin
                p2_reg <= p1_reg;
                q2_reg <= q1_reg;
                p1_reg <= p_new;
                q1_reg <= q_new;
            end
            OP_ADVANCE:
            begin
                num_reg <= den_reg;
                den_reg <= rem_reg;
            end
            OP_PASS:
            begin
                numerator_reg   <= p1_reg;
                denominator_reg <= q1_reg[DEN_W-1:0];
                negative_reg    <= neg_reg;
                failed_reg      <= 1'b0;
            end
            OP_FAIL:
            begin
                numerator_reg   <= '0;
                denominator_reg <= DEN_W'(1);
                negative_reg    <= neg_reg;
                failed_reg      <= 1'b1;
            end
            default:
            begin
                num_reg <= num_reg;
            end
        endcase
    end

    assign busy        = (pc_reg != S_WAIT);
    assign done        = done_reg;
    assign numerator   = numerator_reg;
    assign denominator = denominator_reg;
    assign negative    = negative_reg;
    assign failed      = failed_reg;

endmodule

`default_nettype wire

// ===== rtl/cfa_checker.sv =====
// ============================================================================
// cfa_checker : port-level checks
// Watches the command handshake and result beats of the top level.
// ============================================================================
`default_nettype none

module cfa_checker
    import cfa_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire logic [VALUE_W-1:0] numerator,
    input wire logic [DEN_W-1:0]   denominator,
    input wire logic               failed
);

    // An accepted command makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    // A result beat comes only after the block has gone idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result beat while busy or without work");

    // Busy rises only on a command
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command");

    // A failure beat carries 0/1; every beat has a nonzero denominator
    a_fail_value: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (denominator != '0)
                 && (!failed || (numerator == '0 && denominator == DEN_W'(1))))
        else $error("bad result fraction");

endmodule

bind continued_fraction_approximation cfa_checker u_cfa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .numerator   (numerator),
    .denominator (denominator),
    .failed      (failed)
);

`default_nettype wire

// ===== dv/continued_fraction_approximation_tb.sv =====
// ============================================================================
// continued_fraction_approximation_tb : self-checking bench
// Feeds Q16.32 values through the start/busy handshake, predicts results with
// an exact integer Euclid expansion where the directed table gives none, checks
// each done beat by field and rewrites the tolerance between phases while idle.
// ============================================================================
module continued_fraction_approximation_tb;
    import cfa_pkg::*;

    localparam int WATCHDOG_LIMIT = 50000;
    localparam int SETTLE_CYCLES  = 2 + 154 * MAX_TERMS_DEF;
    localparam int RANDOM_ITEMS   = 280;
    localparam logic [TOL_W-1:0] TOL_MAX = TOL_W'(64'h1_0000_0000);

    typedef struct packed {
        logic [VALUE_W-1:0] numerator;
        logic [DEN_W-1:0]   denominator;
        logic               negative;
        logic               failed;
    } approx_t;

    typedef struct packed {
        logic [TOL_W-1:0]   tol;
        logic [VALUE_W-1:0] val;
        logic               typed;
        approx_t            want;
    } row_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic        [TOL_W-1:0]   cfg_wdata = '0;
    logic                      start     = 1'b0;
    logic signed [VALUE_W-1:0] value     = '0;
    logic                      busy;
    logic                      done;
    logic        [VALUE_W-1:0] numerator;
    logic        [DEN_W-1:0]   denominator;
    logic                      negative;
    logic                      failed;

    approx_t          pending_convergents[$];
    approx_t          due;
    logic [TOL_W-1:0] tol_now = TOL_RESET;
    int               mismatches = 0;
    int               quiet_cycles = 0;

    // Directed rows: zero, integers, halves, pi, extremes of value and tolerance
    row_t plan [23] = '{
        '{TOL_RESET, 49'h0,               1'b1, '{49'd0,     33'd1, 1'b0, 1'b0}},
        '{TOL_RESET, 49'h3_0000_0000,     1'b1, '{49'd3,     33'd1, 1'b0, 1'b0}},
        '{TOL_RESET, 49'h1_FFFD_0000_0000, 1'b1, '{49'd3,    33'd1, 1'b1, 1'b0}},
        '{TOL_RESET, 49'h0_8000_0000,     1'b1, '{49'd1,     33'd2, 1'b0, 1'b0}},
        '{TOL_RESET, 49'h3_243F_6A89,     1'b0, '0},
        '{TOL_RESET, 49'h0_FFFF_FFFF_FFFF, 1'b0, '0},
        '{TOL_RESET, 49'h1_0000_0000_0000, 1'b1, '{49'd65536, 33'd1, 1'b1, 1'b0}},
        '{TOL_RESET, 49'h1_FFFF_FFFF_FFFF, 1'b1, '{49'd0,    33'd1, 1'b1, 1'b0}},
        '{TOL_RESET, 49'h1,               1'b1, '{49'd0,     33'd1, 1'b0, 1'b0}},
        '{33'd1,     49'h0_8000_0000,     1'b1, '{49'd1,     33'd2, 1'b0, 1'b0}},
        '{33'd1,     49'h3_243F_6A89,     1'b0, '0},
        '{33'd1,     49'h0_FFFF_FFFF_FFFF, 1'b0, '0},
        '{33'd1,     49'h0_AAAA_AAAA_AAAA, 1'b0, '0},
        '{33'd1,     49'h1_5555_5555_5555, 1'b0, '0},
        '{TOL_MAX,   49'h0_FFFF_FFFF_FFFF, 1'b1, '{49'd65535, 33'd1, 1'b0, 1'b0}},
        '{TOL_MAX,   49'h1_FFFF_FFFF_FFFF, 1'b1, '{49'd0,    33'd1, 1'b1, 1'b0}},
        '{TOL_MAX,   49'h3_243F_6A89,     1'b1, '{49'd3,     33'd1, 1'b0, 1'b0}},
        '{33'd0,     49'h0,               1'b1, '{49'd0,     33'd1, 1'b0, 1'b1}},
        '{33'd0,     49'h1_FFFD_0000_0000, 1'b1, '{49'd0,    33'd1, 1'b1, 1'b1}},
        '{33'd0,     49'h3_243F_6A89,     1'b1, '{49'd0,     33'd1, 1'b0, 1'b1}},
        '{33'd0,     49'h1_0000_0000_0000, 1'b1, '{49'd0,    33'd1, 1'b1, 1'b1}},
        '{TOL_RESET, 49'h1_9E37_79BA,     1'b0, '0},
        '{TOL_RESET, 49'h1_FFFC_DBC0_9577, 1'b0, '0}
    };

    continued_fraction_approximation uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .start       (start),
        .value       (value),
        .busy        (busy),
        .done        (done),
        .numerator   (numerator),
        .denominator (denominator),
        .negative    (negative),
        .failed      (failed)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Expand |v| / 2^FRAC_BITS term by term; the error of each convergent is
    // the Euclid remainder, tested as floor(rem / q) against the tolerance
    function automatic approx_t best_convergent(input logic [VALUE_W-1:0] v,
                                                input logic [TOL_W-1:0]   tol);
        logic [VALUE_W-1:0] m;
        logic [63:0]        num, den, s, rem, p, q, p2, q2, p1, q1;
        approx_t            r;
        m   = v[VALUE_W-1] ? (~v + 1'b1) : v;
        num = 64'(m);
        den = 64'd1 << FRAC_BITS_DEF;
        p2  = 64'd0;
        q2  = 64'd1;
        p1  = 64'd1;
        q1  = 64'd0;
        r.numerator   = '0;
        r.denominator = DEN_W'(1);
        r.negative    = v[VALUE_W-1];
        r.failed      = 1'b1;
        for (int t = 0; t < MAX_TERMS_DEF; t++)
        begin
            if (den == 64'd0)
                break;
            s   = num / den;
            rem = num - s * den;
            p   = p2 + s * p1;
            q   = q2 + s * q1;
            p2  = p1;
            q2  = q1;
            p1  = p;
            q1  = q;
            if (q != 64'd0 && (rem / q) < 64'(tol))
            begin
                r.numerator   = p[VALUE_W-1:0];
                r.denominator = q[DEN_W-1:0];
                r.failed      = 1'b0;
                break;
            end
            if (rem == 64'd0)
                break;
            num = den;
            den = rem;
        end
        return r;
    endfunction

    // Mostly log-spread tolerances, with the extremes and zero now and then
    function automatic logic [TOL_W-1:0] pick_tolerance();
        int          k;
        logic [63:0] t;
        case ($urandom_range(0, 9))
            0: return TOL_W'(1);
            1: return TOL_MAX;
            2: return TOL_RESET;
            3: return '0;
            default:
            begin
                k = $urandom_range(0, 32);
                t = (64'd1 << k) | ({$urandom, $urandom} & ((64'd1 << k) - 64'd1));
                return (t > 64'(TOL_MAX)) ? TOL_MAX : TOL_W'(t);
            end
        endcase
    endfunction

    // Raw bit patterns, rounded small rationals, tiny, integer and near-integer values
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [63:0]        mag;
        int unsigned        den, num;
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: return VALUE_W'({$urandom, $urandom});
            3, 4, 5:
            begin
                den = $urandom_range(1, 4000);
                num = $urandom % (den * 65536);
                mag = ((64'(num) << FRAC_BITS_DEF) + 64'(den / 2)) / 64'(den);
            end
            6: mag = 64'($urandom_range(0, 8191));
            7: mag = 64'($urandom_range(0, 65535)) << FRAC_BITS_DEF;
            8: mag = (64'($urandom_range(1, 65535)) << FRAC_BITS_DEF)
                     - 64'($urandom_range(1, 63));
            default:
            begin
                case ($urandom_range(0, 3))
                    0: mag = 64'd0;
                    1: mag = 64'd1;
                    2: mag = (64'd1 << 48) - 64'd1;
                    default: mag = 64'd1 << 48;
                endcase
            end
        endcase
        v = VALUE_W'(mag);
        return $urandom_range(0, 1) ? (~v + 1'b1) : v;
    endfunction

    // Hold start until a beat is taken, then queue its expected convergent
    task automatic feed_value(input logic [VALUE_W-1:0] v, input int gap,
                              input approx_t want);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_convergents.push_back(want);
    endtask

    // Drop start and wait for every outstanding result
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_convergents.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic set_tolerance(input logic [TOL_W-1:0] tol);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= tol;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tol_now = tol;
    endtask

    // Check each done beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_convergents.size() == 0)
            begin
                $error("result beat with no value outstanding");
                mismatches++;
            end
            else
            begin
                due = pending_convergents.pop_front();
                if (numerator !== due.numerator)
                begin
                    $error("numerator: expected %0d, got %0d", due.numerator, numerator);
                    mismatches++;
                end
                if (denominator !== due.denominator)
                begin
                    $error("denominator: expected %0d, got %0d",
                           due.denominator, denominator);
                    mismatches++;
                end
                if (negative !== due.negative)
                begin
                    $error("negative: expected %0b, got %0b", due.negative, negative);
                    mismatches++;
                end
                if (failed !== due.failed)
                begin
                    $error("failed: expected %0b, got %0b", due.failed, failed);
                    mismatches++;
                end
            end
        end
    end

    // Abort when no beat moves on either side for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        approx_t          want;
        logic [VALUE_W-1:0] v;
        logic [TOL_W-1:0] tol;
        int               gap;
        int               roll;
        int               items;
        int               phase_len;
        bit               quiet;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table, rewriting the tolerance where a row asks
        foreach (plan[i])
        begin
            if (plan[i].tol != tol_now)
                set_tolerance(plan[i].tol);
            want = plan[i].typed ? plan[i].want : best_convergent(plan[i].val, tol_now);
            feed_value(plan[i].val, $urandom_range(0, 2), want);
        end

        // Random phases, each under its own tolerance
        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            tol = pick_tolerance();
            set_tolerance(tol);
            phase_len = (tol == '0) ? 3 : $urandom_range(20, 40);
            quiet     = ($urandom_range(0, 3) == 0);
            repeat (phase_len)
            begin
                if ($urandom_range(0, 39) == 0)
                    drain_results();
                roll = $urandom_range(0, 19);
                if (quiet || roll < 12)
                    gap = 0;
                else if (roll < 18)
                    gap = $urandom_range(1, 3);
                else
                    gap = $urandom_range(20, 150);
                v = pick_value();
                feed_value(v, gap, best_convergent(v, tol_now));
                items++;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && pending_convergents.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
